### hdl/pse_pkg.sv
package pse_pkg;

  localparam int POS_W      = 32;
  localparam int TS_IN_W    = 32;
  localparam int REC_W      = 64;
  localparam int WIN_W      = 16;
  localparam int CNT_W      = 7;
  localparam int VEL_W      = 24;
  localparam int FRAC_SHIFT = 9;
  localparam int DIST_W     = POS_W + 1;
  localparam int QUO_W      = DIST_W + FRAC_SHIFT;
  localparam int SLOPE_W    = QUO_W + 1;
  localparam int VSUM_W     = SLOPE_W + 1;
  localparam int DIV_STEPS  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [VSUM_W-1:0] VEL_MAX = VSUM_W'(2**(VEL_W-1) - 1);
  localparam logic signed [VSUM_W-1:0] VEL_MIN = -VEL_MAX - VSUM_W'(1);

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBMODE = 1'b0,
    CFG_FIXED   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_sts_t;

endpackage

### hdl/pse_if.sv
interface pse_in_if import pse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [POS_W-1:0] position;
  logic [TS_IN_W-1:0]      timestamp;

  modport source (output valid, kind, position, timestamp, input ready);
  modport sink   (input valid, kind, position, timestamp, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REC_W-1:0] record;

  modport source (output valid, record, input ready);
  modport sink   (input valid, record, output ready);
endinterface

interface pse_cfg_if import pse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pse_divider.sv
module pse_divider import pse_pkg::*; #(
  parameter int DIVISOR_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [QUO_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [QUO_W-1:0]     quotient,
  output div_sts_t             sts
);

  localparam int CYC    = QUO_W / DIV_STEPS;
  localparam int CYC_CW = $clog2(CYC);

  logic [DIVISOR_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [CYC_CW-1:0]    cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {rem_nxt, quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CYC_CW'(1);
        if (cnt_r == CYC_CW'(CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient   = quo_r;
  assign sts.done   = done_r;
  assign sts.rem_nz = |rem_r;

endmodule

### hdl/pvt_setpoint_record_encoder.sv
// sequence: a flush record passes through emit, a PT record through prep and emit, before it is registered
// a PVT record with a next point goes through prep, two divides with load and wait steps each,
// and emit
// flow: one item at a time, the next beat can be taken in the cycle after the record is loaded;
// an output stall holds the encoder in emit
// a point that only fills the hold slot, a start, an empty flush or an unknown kind is taken in idle alone
// reset: synchronous active-low rst_n clears state, config, held and previous point, counter and output valid
module pvt_setpoint_record_encoder import pse_pkg::*; #(
  parameter int TIMESTAMP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pse_cfg_if.sink    cfg_ch,
  pse_in_if.sink     in_ch,
  pse_out_if.source  out_ch
);

  localparam int TW = TIMESTAMP_BITS;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_LD1  = 7'b0000100,
    ST_W1   = 7'b0001000,
    ST_LD2  = 7'b0010000,
    ST_W2   = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic                     submode_r;
  logic [WIN_W-1:0]         fixed_r;
  logic signed [POS_W-1:0]  held_pos_r, prev_pos_r, in_pos_r;
  logic [TW-1:0]            held_time_r, prev_time_r, in_ts_r;
  logic                     held_valid_r, start_known_r;
  logic [CNT_W-1:0]         integ_r;
  logic [1:0]               in_kind_r;
  logic                     neg_r, tz_r;
  logic signed [VSUM_W-1:0] vsum_r;
  logic                     out_valid_r;
  logic [REC_W-1:0]         out_rec_r;

  logic                     in_fire, emit_fire, out_free, fixed_mode, have_next, in_sum;
  logic [TW-1:0]            t1, t2, ticks, ts_in;
  logic signed [POS_W-1:0]  d_from, d_to;
  logic signed [DIST_W-1:0] seg_diff;
  logic [DIST_W-1:0]        dist_mag;
  logic [QUO_W-1:0]         quotient;
  div_sts_t                 div_sts;
  logic                     div_start;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [VSUM_W-1:0] vsum_add, vq;
  logic [VEL_W-1:0]         vel, vel_use;
  logic [WIN_W-1:0]         window;
  logic [REC_W-1:0]         rec;

  // config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      submode_r <= 1'b0;
      fixed_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SUBMODE: submode_r <= cfg_ch.data[0];
        CFG_FIXED:   fixed_r   <= cfg_ch.data;
      endcase
    end
  end

  // handshakes
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign emit_fire     = (state_r == ST_EMIT) && out_free;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.record = out_rec_r;
  assign ts_in         = TW'(in_ch.timestamp);

  // tick intervals and segment distance
  assign fixed_mode = (fixed_r != '0);
  assign have_next  = (in_kind_r == KIND_POINT);
  assign t1         = fixed_mode ? TW'(fixed_r) : held_time_r - prev_time_r;
  assign t2         = fixed_mode ? TW'(fixed_r) : in_ts_r - held_time_r;
  assign ticks      = (state_r == ST_LD2) ? t2 : t1;
  assign d_from     = (state_r == ST_LD2) ? held_pos_r : prev_pos_r;
  assign d_to       = (state_r == ST_LD2) ? in_pos_r : held_pos_r;
  assign seg_diff   = {d_to[POS_W-1], d_to} - {d_from[POS_W-1], d_from};
  assign dist_mag   = seg_diff[DIST_W-1] ? DIST_W'(-seg_diff) : DIST_W'(seg_diff);
  assign div_start  = (state_r == ST_LD1) || (state_r == ST_LD2);

  pse_divider #(
    .DIVISOR_W (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dist_mag, {FRAC_SHIFT{1'b0}}}),
    .divisor  (ticks),
    .quotient (quotient),
    .sts      (div_sts)
  );

  // floored slope, zero over zero ticks
  always_comb begin
    if (tz_r) begin
      slope = '0;
    end else if (neg_r) begin
      slope = -($signed({1'b0, quotient}) + SLOPE_W'(div_sts.rem_nz));
    end else begin
      slope = $signed({1'b0, quotient});
    end
  end

  assign in_sum   = (state_r == ST_W2);
  assign vsum_add = (in_sum ? vsum_r : '0) + {slope[SLOPE_W-1], slope};

  // mean of slopes, floored, saturated to 16.8
  assign vq = vsum_r >>> 2;
  always_comb begin
    priority if (vq > VEL_MAX) begin
      vel = VEL_MAX[VEL_W-1:0];
    end else if (vq < VEL_MIN) begin
      vel = VEL_MIN[VEL_W-1:0];
    end else begin
      vel = vq[VEL_W-1:0];
    end
  end

  assign vel_use = have_next ? vel : '0;
  assign window  = t1[WIN_W-1:0];

  always_comb begin
    if (submode_r) begin
      rec = {integ_r, window[8:0], vel_use[VEL_W-1:8], held_pos_r[23:16],
             vel_use[7:0], held_pos_r[15:0]};
    end else begin
      rec = {integ_r, 9'd0, window, held_pos_r};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && held_valid_r) begin
          if (in_ch.kind == KIND_POINT) begin
            state_nxt = ST_PREP;
          end else if (in_ch.kind == KIND_FLUSH) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_PREP: state_nxt = submode_r ? ST_LD1 : ST_EMIT;
      ST_LD1:  state_nxt = ST_W1;
      ST_W1:   state_nxt = div_sts.done ? ST_LD2 : ST_W1;
      ST_LD2:  state_nxt = ST_W2;
      ST_W2:   state_nxt = div_sts.done ? ST_EMIT : ST_W2;
      ST_EMIT: state_nxt = out_free ? ST_IDLE : ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_pos_r    <= '0;
      held_time_r   <= '0;
      held_valid_r  <= 1'b0;
      prev_pos_r    <= '0;
      prev_time_r   <= '0;
      start_known_r <= 1'b0;
      integ_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        if (in_ch.kind == KIND_POINT && !held_valid_r) begin
          held_pos_r   <= in_ch.position;
          held_time_r  <= ts_in;
          held_valid_r <= 1'b1;
        end else if (in_ch.kind == KIND_START) begin
          prev_pos_r    <= in_ch.position;
          prev_time_r   <= '0;
          start_known_r <= 1'b0;
          held_valid_r  <= 1'b0;
          held_pos_r    <= '0;
          held_time_r   <= '0;
        end
      end
      // start time inferred from the first two points
      if (state_r == ST_PREP && !start_known_r) begin
        prev_time_r   <= (held_time_r << 1) - in_ts_r;
        start_known_r <= 1'b1;
      end
      if (emit_fire) begin
        out_valid_r   <= 1'b1;
        prev_pos_r    <= held_pos_r;
        prev_time_r   <= held_time_r;
        start_known_r <= 1'b1;
        integ_r       <= integ_r + CNT_W'(1);
        if (have_next) begin
          held_pos_r   <= in_pos_r;
          held_time_r  <= in_ts_r;
          held_valid_r <= 1'b1;
        end else begin
          held_valid_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_kind_r <= in_ch.kind;
      in_pos_r  <= in_ch.position;
      in_ts_r   <= ts_in;
    end
    if (div_start) begin
      neg_r <= seg_diff[DIST_W-1];
      tz_r  <= (ticks == '0);
    end
    if ((state_r == ST_W1 || state_r == ST_W2) && div_sts.done) begin
      vsum_r <= vsum_add;
    end
    if (emit_fire) begin
      out_rec_r <= rec;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_W1 || state_r == ST_W2))
    else $error("divider finished outside a wait step");

  a_emit_has_point: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> held_valid_r)
    else $error("record emitted with no held point");

  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (integ_r == $past(integ_r) + CNT_W'(1)) && out_valid_r)
    else $error("integrity counter did not advance with a record");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.kind == KIND_START) |=> !held_valid_r && !start_known_r)
    else $error("start did not clear the held point");

endmodule

### dv/pvt_setpoint_record_encoder_tb.sv
`timescale 1ns / 100ps

module pvt_setpoint_record_encoder_tb import pse_pkg::*; ();

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 220;
  localparam longint     VEL_TOP       = 64'sd8388607;
  localparam longint     VEL_BOTTOM    = -64'sd8388608;
  localparam int         N_ROWS        = 23;
  localparam int         EXP_DEPTH     = 4096;

  typedef struct packed {
    bit          cfg_row;
    bit          pvt;
    logic [15:0] win;
    logic [1:0]  kind;
    logic [31:0] pos;
    logic [31:0] ts;
    bit          typed;
    bit          has_rec;
    logic [63:0] rec;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pse_in_if  in_bus ();
  pse_out_if out_bus ();
  pse_cfg_if cfg_bus ();

  pvt_setpoint_record_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // encoder state mirror
  logic [31:0] hold_pos, hold_ts, last_pos, last_ts;
  bit          hold_ok, origin_known;
  logic [6:0]  rec_cnt;
  bit          pvt_mode;
  logic [15:0] win_fixed;

  logic [63:0] expected_recs [EXP_DEPTH];
  int          exp_head, exp_tail;
  int          mismatch_count;
  int          idle_mode;

  dir_row_t dir_rows [N_ROWS] = '{
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h7FFF_FFFF, 32'd10, 1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h8000_0000, 32'd30, 1'b1, 1'b1,
      64'h0000_0014_7FFF_FFFF},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b1, 1'b1, 64'h0200_0014_8000_0000},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_START,  32'd100, 32'd0, 1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b1, 1'b1, 64'h0400_FFFF_0000_0000},
    '{1'b1, 1'b1, 16'd0, KIND_POINT,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'hFFFF_FFFB, 32'd100, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h7FFF_FFFF, 32'd100, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h8000_0000, 32'd101, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h7FFF_FFFF, 32'd102, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b1, 16'hFFFF, KIND_POINT, 32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'd12345, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'hFFFF_CFC7, 32'd5, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h00FF_FF00, 32'd9, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 16'd1, KIND_POINT,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_POINT,  32'h55AA_55AA, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 16'd0, KIND_FLUSH,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 16'd0, KIND_POINT,  32'd0, 32'd0, 1'b0, 1'b0, 64'd0}
  };

  // distance * 512 / ticks, floored; zero ticks give zero
  function automatic longint floor_slope(logic [31:0] from_pos, logic [31:0] to_pos,
                                         logic [31:0] ticks);
    longint diff, den, q;
    diff = (longint'($signed(to_pos)) - longint'($signed(from_pos))) * 512;
    if (ticks == 0) return 0;
    den = longint'({32'd0, ticks});
    q = diff / den;
    if (diff < 0 && q * den != diff) q = q - 1;
    return q;
  endfunction

  function automatic logic [63:0] encode_record(bit next_ok, logic [31:0] next_pos,
                                                logic [31:0] next_ts);
    logic [31:0] span, t1, t2;
    logic [15:0] win;
    longint      vel;
    logic [23:0] vbits;
    logic [63:0] rec;
    span  = hold_ts - last_ts;
    win   = (win_fixed != 0) ? win_fixed : span[15:0];
    vbits = '0;
    if (!pvt_mode) begin
      rec = {rec_cnt, 9'd0, win, hold_pos};
    end else begin
      if (next_ok) begin
        t1  = (win_fixed != 0) ? {16'd0, win_fixed} : span;
        t2  = (win_fixed != 0) ? {16'd0, win_fixed} : next_ts - hold_ts;
        vel = (floor_slope(last_pos, hold_pos, t1) + floor_slope(hold_pos, next_pos, t2))
              >>> 2;
        if (vel > VEL_TOP) vel = VEL_TOP;
        if (vel < VEL_BOTTOM) vel = VEL_BOTTOM;
        vbits = vel[23:0];
      end
      rec = {rec_cnt, win[8:0], vbits[23:8], hold_pos[23:16], vbits[7:0], hold_pos[15:0]};
    end
    last_pos     = hold_pos;
    last_ts      = hold_ts;
    origin_known = 1'b1;
    rec_cnt      = rec_cnt + 7'd1;
    hold_ok      = 1'b0;
    return rec;
  endfunction

  function automatic bit predict_record(logic [1:0] kind, logic [31:0] pos,
                                        logic [31:0] ts, output logic [63:0] rec);
    bit made;
    made = 1'b0;
    rec  = '0;
    case (kind)
      KIND_POINT: begin
        if (hold_ok) begin
          // start time inferred from the first two points
          if (!origin_known) begin
            last_ts      = (hold_ts << 1) - ts;
            origin_known = 1'b1;
          end
          rec  = encode_record(1'b1, pos, ts);
          made = 1'b1;
        end
        hold_pos = pos;
        hold_ts  = ts;
        hold_ok  = 1'b1;
      end
      KIND_FLUSH: begin
        if (hold_ok) begin
          rec  = encode_record(1'b0, '0, '0);
          made = 1'b1;
        end
      end
      KIND_START: begin
        last_pos     = pos;
        last_ts      = '0;
        origin_known = 1'b0;
        hold_ok      = 1'b0;
        hold_pos     = '0;
        hold_ts      = '0;
      end
      default: ;
    endcase
    return made;
  endfunction

  function automatic void push_expected(logic [63:0] rec);
    expected_recs[exp_tail % EXP_DEPTH] = rec;
    exp_tail++;
  endfunction

  function automatic bit sender_rests();
    return (idle_mode == 1 && $urandom_range(99) < 61) ||
           (idle_mode == 3 && $urandom_range(99) < 26);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [31:0] pos, logic [31:0] ts,
                           bit typed, bit has_rec, logic [63:0] rec);
    logic [63:0] predicted;
    while (sender_rests()) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.position  <= pos;
    in_bus.timestamp <= ts;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (typed) begin
      void'(predict_record(kind, pos, ts, predicted));
      if (has_rec) push_expected(rec);
    end else if (predict_record(kind, pos, ts, predicted)) begin
      push_expected(predicted);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (exp_tail != exp_head) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(bit pvt, logic [15:0] win);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_SUBMODE;
    cfg_bus.data  <= {15'd0, pvt};
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    pvt_mode = pvt;
    @(negedge clk);
    cfg_bus.index <= CFG_FIXED;
    cfg_bus.data  <= win;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    win_fixed = win;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if ((idle_mode == 2 && $urandom_range(99) < 61) ||
        (idle_mode == 3 && $urandom_range(99) < 26))
      out_bus.ready <= 1'b0;
    else
      out_bus.ready <= 1'b1;
  end

  // record beat check
  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (exp_tail == exp_head) begin
        $display("%0t: unexpected record, expected none, actual %h", $time, out_bus.record);
        mismatch_count++;
      end else begin
        want = expected_recs[exp_head % EXP_DEPTH];
        exp_head++;
        if (out_bus.record !== want) begin
          $display("%0t: record mismatch, expected %h, actual %h",
                   $time, want, out_bus.record);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          sent, r, e;
    bit          paused;
    logic [31:0] walk_pos, walk_ts;
    logic [15:0] win;

    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_POINT;
    in_bus.position  = '0;
    in_bus.timestamp = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_SUBMODE;
    cfg_bus.data     = '0;
    out_bus.ready    = 1'b0;
    idle_mode        = 0;
    mismatch_count   = 0;
    exp_head         = 0;
    exp_tail         = 0;
    hold_pos = '0; hold_ts = '0; last_pos = '0; last_ts = '0;
    hold_ok = 1'b0; origin_known = 1'b0; rec_cnt = '0;
    pvt_mode = 1'b0; win_fixed = '0;
    paused = 1'b0;
    walk_pos = '0;
    walk_ts  = '0;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        settle();
        write_regs(dir_rows[i].pvt, dir_rows[i].win);
      end else begin
        send_item(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].ts,
                  dir_rows[i].typed, dir_rows[i].has_rec, dir_rows[i].rec);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      idle_mode = p % 4;
      if (p == 2) win = 16'hFFFF;
      else if (p == 5) win = 16'd1;
      else if (p % 3 == 0 || p == 7) win = '0;
      else win = 16'($urandom_range(2, 4000));
      write_regs(p >= 4, win);
      if ($urandom_range(1) == 1) begin
        walk_pos = $urandom;
        walk_ts  = $urandom;
        send_item(KIND_START, walk_pos, walk_ts, 1'b0, 1'b0, '0);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 1 && sent == 100 && !paused) begin
          settle();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 80) begin
          e = $urandom_range(99);
          if (e < 8) walk_ts = walk_ts + ((e < 3) ? $urandom : 32'd0);
          else walk_ts = walk_ts + $urandom_range(1, 300);
          e = $urandom_range(99);
          if (e < 4) walk_pos = $urandom;
          else if (e < 6) walk_pos = e[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
          else walk_pos = walk_pos + $urandom_range(0, 4000) - 32'd2000;
          send_item(KIND_POINT, walk_pos, walk_ts, 1'b0, 1'b0, '0);
          sent++;
        end else if (r < 88) begin
          send_item(KIND_FLUSH, $urandom, $urandom, 1'b0, 1'b0, '0);
          sent++;
        end else if (r < 95) begin
          walk_pos = $urandom;
          walk_ts  = $urandom;
          send_item(KIND_START, walk_pos, walk_ts, 1'b0, 1'b0, '0);
          sent++;
        end else begin
          send_item(KIND_UNUSED, $urandom, $urandom, 1'b0, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pse_pkg.sv
hdl/pse_if.sv
hdl/pse_divider.sv
hdl/pvt_setpoint_record_encoder.sv
dv/pvt_setpoint_record_encoder_tb.sv
